// ===== rtl/ggc_pkg.sv =====
// Package for the greedy coloring bound block.
// Holds sizes, request codes, the controller state type and a bit search helper.
// Depends on nothing.
`timescale 1ns / 1ps
package ggc_pkg;
   localparam int VERTICES   = 512;
   localparam int WORDS      = VERTICES / 64;
   localparam int WORD_W     = 64;
   localparam int VTX_W      = $clog2(VERTICES);
   localparam int SLOT_W     = $clog2(WORDS);
   localparam int CNT_W      = 10;
   localparam int ADJ_DEPTH  = VERTICES * WORDS;
   localparam int ADJ_AW     = $clog2(ADJ_DEPTH);
   localparam int ORD_W      = VTX_W + CNT_W;

   typedef enum logic [1:0] {
      REQ_LOAD_ADJ  = 2'd0,
      REQ_LOAD_CAND = 2'd1,
      REQ_RUN       = 2'd2,
      REQ_READ      = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_ADJ
   } state_type;

   function automatic logic [5:0] low_bit(input logic [WORD_W-1:0] w);
      logic [5:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) r = 6'(i);
      end
      return r;
   endfunction
endpackage

// ===== rtl/ggc_ram.sv =====
// Generic single port RAM with a registered read.
// Parameters set width and depth; depends on nothing.
`timescale 1ns / 1ps
module ggc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wdata;
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/greedy_graph_coloring_bound.sv =====
// Top level of the greedy coloring bound block: controller, working sets, output register.
// Depends on ggc_pkg and ggc_ram.
//
// Usage: requests arrive on the req_ channel (valid/stall), one result per request
// leaves on the rsp_ channel. A transfer happens when valid is high and stall low.
// Adjacency words go into a 4096 x 64 RAM at row*8+slot; candidate words go into
// eight registers. A read returns the order entry at a position from a 512 entry RAM.
// Loads answer in the cycle after their transfer; reads pass through the read state first,
// since the order RAM has a registered read. A run scans the class working set one
// 64-bit word per cycle and, for each vertex taken, pauses the scan to read the eight
// words of its adjacency row from the single adjacency RAM port. One request is
// handled at a time; req_stall stays high while a request is in work and while a
// finished result waits under rsp_stall. After reset the candidate set and both
// counts are zero; the RAMs hold nothing defined until written.
`timescale 1ns / 1ps
module greedy_graph_coloring_bound (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [8:0]                    req_row_vertex,
   input  logic [2:0]                    req_word_slot,
   input  logic [63:0]                   req_word_bits,
   input  logic [8:0]                    req_entry_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [8:0]                    rsp_vertex_out,
   output logic [9:0]                    rsp_color_out,
   output logic [9:0]                    rsp_ordered_count,
   output logic [9:0]                    rsp_color_count
);
   localparam int WORDS  = ggc_pkg::WORDS;
   localparam int WORD_W = ggc_pkg::WORD_W;
   localparam int VTX_W  = ggc_pkg::VTX_W;
   localparam int SLOT_W = ggc_pkg::SLOT_W;
   localparam int CNT_W  = ggc_pkg::CNT_W;

   ggc_pkg::state_type state_ff, state_in;
   logic [WORD_W-1:0] cand_ff [WORDS];
   logic [WORD_W-1:0] cand_in [WORDS];
   logic [WORD_W-1:0] left_ff [WORDS];
   logic [WORD_W-1:0] left_in [WORDS];
   logic [WORD_W-1:0] cr_ff [WORDS];
   logic [WORD_W-1:0] cr_in [WORDS];
   logic [SLOT_W:0]   wp_ff, wp_in;
   logic [SLOT_W:0]   adj_cnt_ff, adj_cnt_in;
   logic [VTX_W-1:0]  v_ff, v_in;
   logic [CNT_W-1:0]  color_ff, color_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  order_len_ff, order_len_in;
   logic [CNT_W-1:0]  colors_ff, colors_in;
   logic [VTX_W-1:0]  pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [VTX_W-1:0]  rsp_vertex_ff, rsp_vertex_in;
   logic [CNT_W-1:0]  rsp_color_ff, rsp_color_in;

   logic                     accept;
   logic                     adj_we;
   logic [ggc_pkg::ADJ_AW-1:0] adj_addr;
   logic [WORD_W-1:0]        adj_rdata;
   logic                     ord_we;
   logic [VTX_W-1:0]         ord_addr;
   logic [ggc_pkg::ORD_W-1:0] ord_wdata;
   logic [ggc_pkg::ORD_W-1:0] ord_rdata;
   logic                     left_any;
   logic [5:0]               bit_idx;
   logic [VTX_W-1:0]         pick;
   logic [SLOT_W:0]          adj_prev;

   ggc_ram #(.WIDTH(WORD_W), .DEPTH(ggc_pkg::ADJ_DEPTH)) u_adj_ram (
      .clock(clock), .wr_en(adj_we), .addr(adj_addr),
      .wdata(req_word_bits), .rdata(adj_rdata)
   );

   ggc_ram #(.WIDTH(ggc_pkg::ORD_W), .DEPTH(ggc_pkg::VERTICES)) u_ord_ram (
      .clock(clock), .wr_en(ord_we), .addr(ord_addr),
      .wdata(ord_wdata), .rdata(ord_rdata)
   );

   assign req_stall = (state_ff != ggc_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      left_any = 1'b0;
      for (int w = 0; w < WORDS; w++) left_any = left_any | (|left_ff[w]);
   end

   assign bit_idx  = ggc_pkg::low_bit(cr_ff[wp_ff[SLOT_W-1:0]]);
   assign pick     = {wp_ff[SLOT_W-1:0], bit_idx};
   assign adj_prev = adj_cnt_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      left_in       = left_ff;
      cr_in         = cr_ff;
      wp_in         = wp_ff;
      adj_cnt_in    = adj_cnt_ff;
      v_in          = v_ff;
      color_in      = color_ff;
      count_in      = count_ff;
      order_len_in  = order_len_ff;
      colors_in     = colors_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_color_in  = rsp_color_ff;
      adj_we        = 1'b0;
      adj_addr      = {req_row_vertex, req_word_slot};
      ord_we        = 1'b0;
      ord_addr      = req_entry_position;
      ord_wdata     = {v_ff, color_ff};
      case (state_ff)
         ggc_pkg::ST_IDLE: begin
            if (accept) begin
               pos_in = req_entry_position;
               case (ggc_pkg::req_code_type'(req_type))
                  ggc_pkg::REQ_LOAD_ADJ: begin
                     adj_we        = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b0;
                     rsp_vertex_in = '0;
                     rsp_color_in  = '0;
                  end
                  ggc_pkg::REQ_LOAD_CAND: begin
                     cand_in[req_word_slot] = req_word_bits;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b0;
                     rsp_vertex_in = '0;
                     rsp_color_in  = '0;
                  end
                  ggc_pkg::REQ_RUN: begin
                     left_in  = cand_ff;
                     wp_in    = (SLOT_W + 1)'(WORDS);
                     color_in = '0;
                     count_in = '0;
                     state_in = ggc_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = ggc_pkg::ST_READ;
                  end
               endcase
            end
         end
         ggc_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            if (CNT_W'(pos_ff) < order_len_ff) begin
               rsp_status_in = 1'b0;
               rsp_vertex_in = ord_rdata[ggc_pkg::ORD_W-1:CNT_W];
               rsp_color_in  = ord_rdata[CNT_W-1:0];
            end else begin
               rsp_status_in = 1'b1;
               rsp_vertex_in = '0;
               rsp_color_in  = '0;
            end
            state_in = ggc_pkg::ST_IDLE;
         end
         ggc_pkg::ST_SCAN: begin
            if (wp_ff[SLOT_W]) begin
               if (!left_any) begin
                  order_len_in  = count_ff;
                  colors_in     = color_ff;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = 1'b0;
                  rsp_vertex_in = '0;
                  rsp_color_in  = '0;
                  state_in      = ggc_pkg::ST_IDLE;
               end else begin
                  color_in = color_ff + 1'b1;
                  cr_in    = left_ff;
                  wp_in    = '0;
               end
            end else if (cr_ff[wp_ff[SLOT_W-1:0]] == '0) begin
               wp_in = wp_ff + 1'b1;
            end else begin
               left_in[wp_ff[SLOT_W-1:0]][bit_idx] = 1'b0;
               cr_in[wp_ff[SLOT_W-1:0]][bit_idx]   = 1'b0;
               ord_we     = 1'b1;
               ord_addr   = count_ff[VTX_W-1:0];
               ord_wdata  = {pick, color_ff};
               count_in   = count_ff + 1'b1;
               v_in       = pick;
               adj_cnt_in = '0;
               state_in   = ggc_pkg::ST_ADJ;
            end
         end
         ggc_pkg::ST_ADJ: begin
            adj_addr = {v_ff, adj_cnt_ff[SLOT_W-1:0]};
            if (adj_cnt_ff != '0) begin
               cr_in[adj_prev[SLOT_W-1:0]] = cr_ff[adj_prev[SLOT_W-1:0]] & ~adj_rdata;
            end
            adj_cnt_in = adj_cnt_ff + 1'b1;
            if (adj_cnt_ff[SLOT_W]) state_in = ggc_pkg::ST_SCAN;
         end
         default: begin
            state_in = ggc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ggc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         order_len_ff <= '0;
         colors_ff    <= '0;
         for (int w = 0; w < WORDS; w++) begin
            cand_ff[w] <= '0;
            left_ff[w] <= '0;
            cr_ff[w]   <= '0;
         end
         wp_ff        <= '0;
         adj_cnt_ff   <= '0;
         color_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         order_len_ff <= order_len_in;
         colors_ff    <= colors_in;
         cand_ff      <= cand_in;
         left_ff      <= left_in;
         cr_ff        <= cr_in;
         wp_ff        <= wp_in;
         adj_cnt_ff   <= adj_cnt_in;
         color_ff     <= color_in;
         count_ff     <= count_in;
      end
      v_ff          <= v_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_color_ff  <= rsp_color_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_vertex_out    = rsp_vertex_ff;
   assign rsp_color_out     = rsp_color_ff;
   assign rsp_ordered_count = order_len_ff;
   assign rsp_color_count   = colors_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff != ggc_pkg::ST_IDLE |-> req_stall)
      else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ggc_pkg::VERTICES))
      else $error("order count overflow");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ggc_pkg::ST_READ |-> !rsp_valid_ff)
      else $error("read result would overwrite a pending result");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ggc_pkg::ST_ADJ && adj_cnt_ff[SLOT_W] |=> state_ff == ggc_pkg::ST_SCAN)
      else $error("adjacency sweep did not return to scan");
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for greedy_graph_coloring_bound: loads graphs, runs colorings, reads back.
// A queue-fed driver and a checking monitor compare each response with an in-bench predictor.
// Depends on ggc_pkg and the greedy_graph_coloring_bound RTL.
`timescale 1ns / 1ps
module tb;
   typedef struct {
      ggc_pkg::req_code_type kind;
      logic [8:0]   row;
      logic [2:0]   slot;
      logic [63:0]  bits;
      logic [8:0]   pos;
   } request_type;

   typedef struct {
      logic       status;
      logic [8:0] vertex;
      logic [9:0] color;
      logic [9:0] ocount;
      logic [9:0] ccount;
   } answer_type;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_type;
   logic [8:0]  req_row_vertex, req_entry_position;
   logic [2:0]  req_word_slot;
   logic [63:0] req_word_bits;
   logic        rsp_valid, rsp_stall, rsp_status;
   logic [8:0]  rsp_vertex_out;
   logic [9:0]  rsp_color_out, rsp_ordered_count, rsp_color_count;

   greedy_graph_coloring_bound u_dut (.*);

   request_type pending_reqs[$];
   answer_type  expected_answers[$];
   request_type in_flight;
   int       send_idle_pct, stall_pct, queued;
   int       errors = 0;
   int       cycles = 0;
   bit       hold_sender;

   // Predictor state.
   logic [511:0] adj_rows[512];
   logic [511:0] cand_set;
   logic [8:0]   ord_vertex[512];
   logic [9:0]   ord_color[512];
   int           ord_len, ncolors;

   // Generator bookkeeping: which words of each row were loaded.
   logic [7:0]   row_loaded[512];

   function automatic int lowest_vertex(logic [511:0] s);
      for (int i = 0; i < 512; i++) if (s[i]) return i;
      return 0;
   endfunction

   function automatic void color_candidates();
      logic [511:0] left, cls;
      int v, color, count;
      left = cand_set;
      color = 0;
      count = 0;
      while (left != '0) begin
         color++;
         cls = left;
         while (cls != '0) begin
            v = lowest_vertex(cls);
            left[v] = 1'b0;
            cls[v] = 1'b0;
            cls &= ~adj_rows[v];
            ord_vertex[count] = v[8:0];
            ord_color[count] = color[9:0];
            count++;
         end
      end
      ord_len = count;
      ncolors = color;
   endfunction

   function automatic answer_type predict_answer(request_type r);
      answer_type a;
      a = '{1'b0, 9'd0, 10'd0, 10'd0, 10'd0};
      case (r.kind)
         ggc_pkg::REQ_LOAD_ADJ:  adj_rows[r.row][r.slot*64 +: 64] = r.bits;
         ggc_pkg::REQ_LOAD_CAND: cand_set[r.slot*64 +: 64] = r.bits;
         ggc_pkg::REQ_RUN:       color_candidates();
         ggc_pkg::REQ_READ: begin
            if (r.pos < ord_len) begin
               a.vertex = ord_vertex[r.pos];
               a.color = ord_color[r.pos];
            end else begin
               a.status = 1'b1;
            end
         end
         default: ;
      endcase
      a.ocount = ord_len[9:0];
      a.ccount = ncolors[9:0];
      return a;
   endfunction

   task automatic push_req(ggc_pkg::req_code_type k, int row, int slot, logic [63:0] bits,
                           int pos);
      request_type r;
      r.kind = k;
      r.row = row[8:0];
      r.slot = slot[2:0];
      r.bits = bits;
      r.pos = pos[8:0];
      if (k == ggc_pkg::REQ_LOAD_ADJ) row_loaded[row][slot] = 1'b1;
      pending_reqs.insert(pending_reqs.size(), r);
      queued++;
   endtask

   task automatic load_full_row(int v, logic [511:0] row);
      for (int s = 0; s < 8; s++) push_req(ggc_pkg::REQ_LOAD_ADJ, v, s, row[s*64 +: 64], 0);
   endtask

   function automatic int pick_vertex();
      int p;
      if ($urandom_range(99) < 20) begin
         p = $urandom_range(7);
         return p < 4 ? p : 504 + p;
      end
      return $urandom_range(511);
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(3))
         0: w = w & {$urandom, $urandom};
         1: w = w | {$urandom, $urandom};
         default: ;
      endcase
      return w;
   endfunction

   task automatic graph_episode();
      int k, v, nreads;
      logic [511:0] row, cv, legal;
      k = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(10, 1);
      cv = '0;
      for (int i = 0; i < k; i++) begin
         v = pick_vertex();
         for (int s = 0; s < 8; s++) row[s*64 +: 64] = random_word();
         load_full_row(v, row);
         cv[v] = 1'b1;
      end
      if ($urandom_range(3) == 0)
         push_req(ggc_pkg::REQ_LOAD_ADJ, $urandom_range(511), $urandom_range(7),
                  random_word(), 0);
      if ($urandom_range(2) == 0) begin
         legal = '0;
         for (int i = 0; i < 512; i++) legal[i] = (row_loaded[i] == 8'hFF);
         cv |= {16{$urandom}} & legal & {16{$urandom}};
      end
      for (int s = 0; s < 8; s++) push_req(ggc_pkg::REQ_LOAD_CAND, 0, s, cv[s*64 +: 64], 0);
      if ($urandom_range(4) == 0) push_req(ggc_pkg::REQ_READ, 0, 0, 0, $urandom_range(511));
      push_req(ggc_pkg::REQ_RUN, $urandom_range(511), $urandom_range(7), random_word(), 0);
      nreads = $urandom_range(8, 2);
      for (int i = 0; i < nreads; i++)
         push_req(ggc_pkg::REQ_READ, $urandom_range(511), $urandom_range(7), random_word(),
                  ($urandom_range(5) == 0) ? $urandom_range(511) : $urandom_range(k + 3));
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_answers.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_type <= ggc_pkg::REQ_LOAD_ADJ;
         req_row_vertex <= '0;
         req_word_slot <= '0;
         req_word_bits <= '0;
         req_entry_position <= '0;
      end else begin
         if (req_valid && !req_stall)
            expected_answers.insert(expected_answers.size(), predict_answer(in_flight));
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_reqs.pop_front();
               req_type <= in_flight.kind;
               req_row_vertex <= in_flight.row;
               req_word_slot <= in_flight.slot;
               req_word_bits <= in_flight.bits;
               req_entry_position <= in_flight.pos;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      answer_type a;
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected transfer, status %0d vertex %0d color %0d",
                     $time, rsp_status, rsp_vertex_out, rsp_color_out);
            errors++;
         end else begin
            a = expected_answers.pop_front();
            check_field("status", a.status, rsp_status);
            check_field("vertex_out", a.vertex, rsp_vertex_out);
            check_field("color_out", a.color, rsp_color_out);
            check_field("ordered_count", a.ocount, rsp_ordered_count);
            check_field("color_count", a.ccount, rsp_color_count);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("greedy_graph_coloring_bound: mismatch");
         $finish;
      end
   end

   initial begin
      logic [511:0] r0, r511;
      queued = 0;
      hold_sender = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      cand_set = '0;
      ord_len = 0;
      ncolors = 0;
      for (int i = 0; i < 512; i++) begin
         adj_rows[i] = '0;
         row_loaded[i] = '0;
      end
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty state, an empty run, then two vertices with self loops joined by an edge.
      push_req(ggc_pkg::REQ_READ, 0, 0, 0, 0);
      push_req(ggc_pkg::REQ_RUN, 0, 0, 0, 0);
      push_req(ggc_pkg::REQ_READ, 511, 7, '1, 511);
      r0 = '0;
      r0[0] = 1'b1;
      r0[511] = 1'b1;
      r511 = '0;
      r511[511:448] = '1;
      r511[0] = 1'b1;
      load_full_row(0, r0);
      load_full_row(511, r511);
      push_req(ggc_pkg::REQ_LOAD_CAND, 0, 0, 64'd1, 0);
      push_req(ggc_pkg::REQ_LOAD_CAND, 0, 7, 64'h8000_0000_0000_0000, 0);
      push_req(ggc_pkg::REQ_RUN, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++) push_req(ggc_pkg::REQ_READ, 0, 0, 0, i);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 69; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 69; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         while (queued < (ph + 1) * 113) begin
            graph_episode();
            if ($urandom_range(3) == 0) begin
               drain();
               hold_sender = 1'b1;
               repeat ($urandom_range(5, 1)) @(posedge clock);
               hold_sender = 1'b0;
            end
         end
         drain();
      end
      repeat (20) @(posedge clock);
      if (errors == 0) $display("greedy_graph_coloring_bound: match");
      else $display("greedy_graph_coloring_bound: mismatch");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/ggc_pkg.sv
rtl/ggc_ram.sv
rtl/greedy_graph_coloring_bound.sv
sim/tb.sv
